@@ rtl/vpae_pkg.sv @@
// Package for the video port access engine: types, codes and colour packing.
`timescale 1ns / 1ps
package vpae_pkg;

  // Port access kinds carried by the op field.
  localparam logic [1:0] OP_CTRL_WR = 2'd0;
  localparam logic [1:0] OP_DATA_WR = 2'd1;
  localparam logic [1:0] OP_DATA_RD = 2'd2;
  localparam logic [1:0] OP_STAT_RD = 2'd3;

  // Store selection by the low four code bits.
  localparam logic [3:0] CODE_VID_WR = 4'h1;
  localparam logic [3:0] CODE_COL_WR = 4'h3;
  localparam logic [3:0] CODE_SCR_WR = 4'h5;
  localparam logic [3:0] CODE_VID_RD = 4'h0;
  localparam logic [3:0] CODE_COL_RD = 4'h8;
  localparam logic [3:0] CODE_SCR_RD = 4'h4;

  // Register numbers with a fixed meaning.
  localparam int REG_MODE2   = 1;
  localparam int REG_BGCOL   = 7;
  localparam int REG_STEP    = 15;
  localparam int REG_LEN_LO  = 19;
  localparam int REG_LEN_HI  = 20;
  localparam int REG_SRC_LO  = 21;
  localparam int REG_SRC_HI  = 22;
  localparam int REG_XFER    = 23;
  localparam int NUM_REGS    = 32;

  // Transfer modes held in register 23 bits 7..6.
  localparam logic [1:0] XFER_FILL = 2'b10;
  localparam logic [1:0] XFER_COPY = 2'b11;

  localparam logic [15:0] STATUS_RESET = 16'h3600;
  localparam logic [15:0] FIFO_TOGGLE  = 16'h0300;
  localparam logic [15:0] STATUS_KEEP  = 16'hFF9F;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WR0,
    S_WR1,
    S_RD1,
    S_RD2,
    S_RDM,
    S_COPY_RD,
    S_COPY_WR,
    S_FILL0,
    S_FILL1,
    S_DONE
  } vpae_state_e;

  // Pack a bus colour word into nine bits, three per component.
  function automatic logic [8:0] pack_colour(input logic [15:0] d);
    return {d[3:1], d[7:5], d[11:9]};
  endfunction

  // Expand a nine-bit colour back to its bus layout.
  function automatic logic [15:0] unpack_colour(input logic [8:0] d);
    return {4'd0, d[2:0], 1'b0, d[5:3], 1'b0, d[8:6], 1'b0};
  endfunction

endpackage

@@ rtl/video_port_access_engine_unit.sv @@
// Video port access engine: port decode, register file, stores and transfer sequencer.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid_i/in_stall_o | op_i, bus_word_i
//  out     | output    | out_valid_o/out_stall_i | read_word_o, address_now_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | pal_mode_i
//
//  Video-memory writes and reads move each word as two bytes through the single
//  byte port of the video memory. A copy reads then writes each byte on that port.
//  After reset a clearing pass zeroes the video memory; no word is accepted
//  during it. Configuration words are taken at any time.
//  A finished result waits in the output register while the next word is accepted.
module video_port_access_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] bus_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_word_o,
  output logic [15:0] address_now_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        pal_mode_i
);
  import vpae_pkg::*;

  vpae_state_e state_q, state_d;

  logic [1:0]  op_q;
  logic [15:0] word_q;
  logic [7:0]  ctrl_q [NUM_REGS];
  logic [7:0]  ctrl_d [NUM_REGS];
  logic [15:0] addr_q, addr_d;
  logic [1:0]  latch_q, latch_d;
  logic [5:0]  code_q, code_d;
  logic        due_q, due_d;
  logic        fill_q, fill_d;
  logic [15:0] status_q, status_d;
  logic        pal_q;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] src_q, src_d;
  logic [15:0] res_q, res_d;
  logic [7:0]  lo_q, lo_d;
  logic [15:0] clr_q;
  logic        out_valid_q;
  logic [15:0] out_word_q, out_addr_q;

  // Video memory port.
  logic        vw_en;
  logic [15:0] vw_addr;
  logic [7:0]  vw_data;
  logic [15:0] vr_addr;
  logic [7:0]  vr_data_q;
  logic [7:0]  vmem [65536];

  // Colour and scroll stores with per-entry valid bits.
  logic        cw_en, sw_en;
  logic [8:0]  cmem [64];
  logic [15:0] smem [64];
  logic [63:0] cvld_q, svld_q;
  logic [8:0]  cr_data_q;
  logic [15:0] sr_data_q;
  logic        cr_vld_q, sr_vld_q;

  logic        in_take, out_load;
  logic [5:0]  small_idx;
  logic [15:0] step_addr, vid_a, swapped, len_m1, st_next;
  logic [15:0] new_addr;
  logic [5:0]  new_code;
  logic [4:0]  reg_idx;

  assign in_take     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o   = out_valid_q;
  assign read_word_o   = out_word_q;
  assign address_now_o = out_addr_q;

  assign small_idx = addr_q[6:1];
  assign step_addr = addr_q + {8'd0, ctrl_q[REG_STEP]};
  assign vid_a     = {addr_q[15:1], 1'b0};
  assign swapped   = addr_q[0] ? {word_q[7:0], word_q[15:8]} : word_q;
  assign len_m1    = {ctrl_q[REG_LEN_HI], ctrl_q[REG_LEN_LO]} - 16'd1;
  assign new_addr  = {word_q[1:0], addr_q[13:0]};
  assign new_code  = {word_q[7:4], code_q[1:0]};
  assign reg_idx   = word_q[12:8];

  // Status after a status read: fifo bits toggle, flags clear.
  always_comb begin
    st_next = (status_q ^ FIFO_TOGGLE) & STATUS_KEEP;
    if (!st_next[3]) begin
      st_next[7] = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == 16'hFFFF) state_d = S_IDLE;
      S_IDLE:  if (in_take) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_CTRL_WR: begin
            if (due_q && new_code[5] && ctrl_q[REG_MODE2][4]
                && ctrl_q[REG_XFER][7:6] == XFER_COPY) begin
              state_d = S_COPY_RD;
            end
          end
          OP_DATA_WR: begin
            if (fill_q) begin
              state_d = S_FILL0;
            end else if (code_q[3:0] == CODE_VID_WR) begin
              state_d = S_WR0;
            end
          end
          OP_DATA_RD: begin
            case (code_q[3:0])
              CODE_VID_RD: state_d = S_RD1;
              CODE_COL_RD: state_d = S_RDM;
              CODE_SCR_RD: state_d = S_RDM;
              default:     state_d = S_DONE;
            endcase
          end
          default: state_d = S_DONE;
        endcase
      end
      S_WR0:     state_d = S_WR1;
      S_WR1:     state_d = S_DONE;
      S_RD1:     state_d = S_RD2;
      S_RD2:     state_d = S_DONE;
      S_RDM:     state_d = S_DONE;
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: state_d = (cnt_q == 16'd0) ? S_DONE : S_COPY_RD;
      S_FILL0:   state_d = S_FILL1;
      S_FILL1:   if (cnt_q == 16'd0) state_d = S_DONE;
      S_DONE:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath updates and memory strobes for each state.
  always_comb begin
    ctrl_d   = ctrl_q;
    addr_d   = addr_q;
    latch_d  = latch_q;
    code_d   = code_q;
    due_d    = due_q;
    fill_d   = fill_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    src_d    = src_q;
    res_d    = res_q;
    lo_d     = lo_q;
    vw_en    = 1'b0;
    vw_addr  = addr_q;
    vw_data  = 8'd0;
    vr_addr  = vid_a;
    cw_en    = 1'b0;
    sw_en    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        vw_en   = 1'b1;
        vw_addr = clr_q;
      end
      S_EXEC: begin
        res_d = 16'd0;
        case (op_q)
          OP_CTRL_WR: begin
            if (!due_q) begin
              // First word: register set or low address part.
              if (word_q[15:14] == 2'b10) begin
                ctrl_d[reg_idx] = (reg_idx == 5'(REG_BGCOL)) ? {2'b00, word_q[5:0]}
                                                            : word_q[7:0];
              end else begin
                due_d = 1'b1;
              end
              addr_d = {latch_q, word_q[13:0]};
              code_d = {code_q[5:2], word_q[15:14]};
            end else begin
              // Second word: high address, high code, optional transfer.
              due_d   = 1'b0;
              addr_d  = new_addr;
              code_d  = new_code;
              latch_d = word_q[1:0];
              if (new_code[5] && ctrl_q[REG_MODE2][4]) begin
                if (ctrl_q[REG_XFER][7:6] == XFER_FILL) begin
                  fill_d = 1'b1;
                end else if (ctrl_q[REG_XFER][7:6] == XFER_COPY) begin
                  cnt_d = len_m1;
                  src_d = {ctrl_q[REG_SRC_HI], ctrl_q[REG_SRC_LO]};
                end
              end
            end
          end
          OP_DATA_WR: begin
            due_d = 1'b0;
            if (fill_q) begin
              cnt_d = len_m1;
            end else begin
              case (code_q[3:0])
                CODE_VID_WR: ;
                CODE_COL_WR: begin
                  cw_en  = 1'b1;
                  addr_d = step_addr;
                end
                CODE_SCR_WR: begin
                  sw_en  = 1'b1;
                  addr_d = step_addr;
                end
                default: addr_d = step_addr;
              endcase
            end
          end
          OP_DATA_RD: begin
            due_d   = 1'b0;
            vr_addr = vid_a;
            case (code_q[3:0])
              CODE_VID_RD: ;
              CODE_COL_RD: ;
              CODE_SCR_RD: ;
              default:     addr_d = step_addr;
            endcase
          end
          default: begin
            due_d    = 1'b0;
            res_d    = status_q | {15'd0, pal_q}
                       | (ctrl_q[REG_MODE2][6] ? 16'h0000 : 16'h0008);
            status_d = st_next;
          end
        endcase
      end
      S_WR0: begin
        vw_en   = 1'b1;
        vw_addr = vid_a;
        vw_data = swapped[7:0];
      end
      S_WR1: begin
        vw_en   = 1'b1;
        vw_addr = vid_a | 16'd1;
        vw_data = swapped[15:8];
        addr_d  = step_addr;
      end
      S_RD1: begin
        vr_addr = vid_a | 16'd1;
        lo_d    = vr_data_q;
      end
      S_RD2: begin
        res_d  = {vr_data_q, lo_q};
        addr_d = step_addr;
      end
      S_RDM: begin
        if (code_q[3:0] == CODE_COL_RD) begin
          res_d = cr_vld_q ? unpack_colour(cr_data_q) : 16'd0;
        end else begin
          res_d = sr_vld_q ? sr_data_q : 16'd0;
        end
        addr_d = step_addr;
      end
      S_COPY_RD: vr_addr = src_q;
      S_COPY_WR: begin
        vw_en   = 1'b1;
        vw_addr = addr_q;
        vw_data = vr_data_q;
        src_d   = src_q + 16'd1;
        addr_d  = step_addr;
        cnt_d   = cnt_q - 16'd1;
        if (cnt_q == 16'd0) begin
          ctrl_d[REG_LEN_LO] = 8'd0;
          ctrl_d[REG_LEN_HI] = 8'd0;
          ctrl_d[REG_SRC_LO] = src_d[7:0];
          ctrl_d[REG_SRC_HI] = src_d[15:8];
        end
      end
      S_FILL0: begin
        vw_en   = 1'b1;
        vw_addr = addr_q ^ 16'd1;
        vw_data = word_q[7:0];
      end
      S_FILL1: begin
        vw_en   = 1'b1;
        vw_addr = addr_q;
        vw_data = word_q[15:8];
        addr_d  = step_addr;
        cnt_d   = cnt_q - 16'd1;
        if (cnt_q == 16'd0) begin
          ctrl_d[REG_LEN_LO] = 8'd0;
          ctrl_d[REG_LEN_HI] = 8'd0;
          fill_d             = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= 16'd0;
      addr_q      <= 16'd0;
      latch_q     <= 2'd0;
      code_q      <= 6'd0;
      due_q       <= 1'b0;
      fill_q      <= 1'b0;
      status_q    <= STATUS_RESET;
      pal_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cvld_q      <= 64'd0;
      svld_q      <= 64'd0;
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_q[i] <= 8'd0;
      end
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      latch_q  <= latch_d;
      code_q   <= code_d;
      due_q    <= due_d;
      fill_q   <= fill_d;
      status_q <= status_d;
      ctrl_q   <= ctrl_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 16'd1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pal_q <= pal_mode_i;
      end
      if (cw_en) begin
        cvld_q[small_idx] <= 1'b1;
      end
      if (sw_en) begin
        svld_q[small_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    src_q <= src_d;
    res_q <= res_d;
    lo_q  <= lo_d;
    if (in_take) begin
      op_q   <= op_i;
      word_q <= bus_word_i;
    end
    if (out_load) begin
      out_word_q <= res_q;
      out_addr_q <= addr_q;
    end
  end

  // Video memory: one byte write and one registered byte read per cycle.
  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      vmem[vw_addr] <= vw_data;
    end
    vr_data_q <= vmem[vr_addr];
  end

  // Colour and scroll memories.
  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      cmem[small_idx] <= pack_colour(word_q);
    end
    if (sw_en) begin
      smem[small_idx] <= word_q;
    end
    cr_data_q <= cmem[small_idx];
    sr_data_q <= smem[small_idx];
    cr_vld_q  <= cvld_q[small_idx];
    sr_vld_q  <= svld_q[small_idx];
  end

  // An accepted word is executed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == S_EXEC)
    else $error("accepted word not executed");

  // A finished result reaches the output register once it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q && state_q == S_IDLE)
    else $error("result not delivered");

  // The last copy byte ends the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY_WR && cnt_q == 16'd0) |=> state_q == S_DONE)
    else $error("copy overran its length");

  // A fill always ends with the fill disarmed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL1 && cnt_q == 16'd0) |=> !fill_q)
    else $error("fill left armed");

endmodule
